// ===== rtl/core/dtdt_pkg.sv =====
package dtdt_pkg;

  localparam int MaxFrac = 10;
  localparam logic [63:0] SatInt = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        sign;
    logic        ovf;
    logic [3:0]  prec;
    logic [63:0] hi;
    logic [63:0] lo;
  } dtdt_job_t;

  function automatic logic [63:0] round_term(input logic [3:0] p);
    logic [63:0] r;
    begin
      case (p)
        4'd1:    r = 64'd922337203685477581;
        4'd2:    r = 64'd92233720368547758;
        4'd3:    r = 64'd9223372036854776;
        4'd4:    r = 64'd922337203685478;
        4'd5:    r = 64'd92233720368548;
        4'd6:    r = 64'd9223372036855;
        4'd7:    r = 64'd922337203685;
        4'd8:    r = 64'd92233720369;
        4'd9:    r = 64'd9223372037;
        4'd10:   r = 64'd922337204;
        default: r = 64'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/dtdt_front.sv =====
module dtdt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         value_bits,
  input  logic [4:0]          precision,
  output logic                job_valid,
  input  logic                job_ready,
  output dtdt_pkg::dtdt_job_t job
);
  import dtdt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_RND, S_OUT} state_t;

  state_t      state;
  logic [63:0] bits;
  logic [4:0]  praw;
  logic        sign;
  logic        ovf;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [3:0]  prec;

  logic [10:0]  e;
  logic [51:0]  f;
  logic [52:0]  m;
  logic [11:0]  kk;
  logic [127:0] wide;
  logic [63:0]  c_hi;
  logic [63:0]  c_lo;
  logic         c_ovf;
  logic [3:0]   c_prec;
  logic [64:0]  sum;
  logic [63:0]  hi_inc;

  assign e = bits[62:52];
  assign f = bits[51:0];
  assign m = (e == 11'd0) ? {1'b0, f} : {1'b1, f};
  assign kk = (e == 11'd0) ? 12'd1074 : 12'd1075 - {1'b0, e};

  always_comb begin
    wide = '0;
    c_hi = '0;
    c_lo = '0;
    c_ovf = 1'b0;
    if (e == 11'h7FF) begin
      c_ovf = 1'b1;
    end else if (e >= 11'd1075) begin
      if (e >= 11'd1086) c_ovf = 1'b1;
      else c_hi = {11'd0, m} << (e - 11'd1075);
    end else if (kk < 12'd128) begin
      wide = {11'd0, m, 64'd0} >> kk[6:0];
      c_hi = wide[127:64];
      c_lo = wide[63:0];
    end
    if (c_ovf || c_hi > SatInt) begin
      c_ovf = 1'b1;
      c_hi = SatInt;
      c_lo = '0;
    end
    if (praw[4]) begin
      if (c_hi < 64'd1) c_prec = 4'd6;
      else if (c_hi < 64'd10) c_prec = 4'd5;
      else if (c_hi < 64'd100) c_prec = 4'd4;
      else if (c_hi < 64'd1000) c_prec = 4'd3;
      else if (c_hi < 64'd10000) c_prec = 4'd2;
      else if (c_hi < 64'd100000) c_prec = 4'd1;
      else c_prec = 4'd0;
    end else if (praw > 5'(MaxFrac)) begin
      c_prec = 4'(MaxFrac);
    end else begin
      c_prec = praw[3:0];
    end
  end

  assign sum = {1'b0, lo} + {1'b0, round_term(prec)};
  assign hi_inc = hi + 64'(sum[64]);

  assign in_ready = (state == S_IDLE);
  assign job_valid = (state == S_OUT);
  assign job = '{sign: sign, ovf: ovf, prec: prec, hi: hi, lo: lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          bits <= value_bits;
          praw <= precision;
          sign <= value_bits[63] && (value_bits[62:0] != 63'd0) &&
                  !(value_bits[62:52] == 11'h7FF && value_bits[51:0] != 52'd0);
          state <= S_CONV;
        end
        S_CONV: begin
          hi <= c_hi;
          lo <= c_lo;
          ovf <= c_ovf;
          prec <= c_prec;
          state <= S_RND;
        end
        S_RND: begin
          if (prec != 4'd0) begin
            if (hi_inc > SatInt) begin
              ovf <= 1'b1;
              hi <= SatInt;
              lo <= '0;
            end else begin
              hi <= hi_inc;
              lo <= sum[63:0];
            end
          end
          state <= S_OUT;
        end
        S_OUT: if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dtdt_queue.sv =====
module dtdt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  dtdt_pkg::dtdt_job_t wr_job,
  output logic                rd_valid,
  input  logic                rd_ready,
  output dtdt_pkg::dtdt_job_t rd_job
);
  import dtdt_pkg::*;

  dtdt_job_t mem [2];
  logic      wp;
  logic      rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

// ===== rtl/core/dtdt_back.sv =====
module dtdt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  dtdt_pkg::dtdt_job_t job,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [7:0]          m_char,
  output logic                m_last,
  output logic                m_ovf
);
  import dtdt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SIGN, S_INT, S_DOT, S_FRAC} state_t;

  state_t      state;
  logic [63:0] quo;
  logic [3:0]  rem;
  logic [2:0]  bcnt;
  logic [3:0]  dig [19];
  logic [4:0]  nd;
  logic [4:0]  di;
  logic [3:0]  prec;
  logic [3:0]  fc;
  logic [63:0] lo;
  logic        sign;
  logic        ovf;
  logic        out_v;
  logic [7:0]  out_c;
  logic        out_l;
  logic        out_o;

  logic [19:0] dvd;
  logic [39:0] dprod;
  logic [15:0] qc;
  logic [19:0] dres;
  logic [67:0] lo10;

  // divide a 16-bit chunk with its running remainder by ten
  assign dvd = {rem, quo[63:48]};
  assign dprod = {20'd0, dvd} * 40'd838861;
  assign qc = dprod[38:23];
  assign dres = dvd - {4'd0, qc} * 20'd10;
  assign lo10 = {4'd0, lo} * 68'd10;

  assign job_ready = (state == S_IDLE);
  assign m_valid = out_v;
  assign m_char = out_c;
  assign m_last = out_l;
  assign m_ovf = out_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_v <= 1'b0;
    end else begin
      if (out_v && m_ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) begin
          quo <= job.hi;
          lo <= job.lo;
          prec <= job.prec;
          sign <= job.sign;
          ovf <= job.ovf;
          rem <= 4'd0;
          bcnt <= 3'd0;
          nd <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (bcnt == 3'd4) begin
            dig[nd] <= rem;
            nd <= nd + 5'd1;
            rem <= 4'd0;
            bcnt <= 3'd0;
            if (quo == 64'd0) begin
              di <= nd;
              state <= S_SIGN;
            end
          end else begin
            rem <= dres[3:0];
            quo <= {quo[47:0], qc};
            bcnt <= bcnt + 3'd1;
          end
        end
        S_SIGN: begin
          if (!sign) begin
            state <= S_INT;
          end else if (!out_v || m_ready) begin
            out_v <= 1'b1;
            out_c <= 8'h2D;
            out_l <= 1'b0;
            out_o <= ovf;
            state <= S_INT;
          end
        end
        S_INT: if (!out_v || m_ready) begin
          out_v <= 1'b1;
          out_c <= 8'h30 + {4'd0, dig[di]};
          out_l <= (di == 5'd0) && (prec == 4'd0);
          out_o <= ovf;
          di <= di - 5'd1;
          if (di == 5'd0) state <= (prec == 4'd0) ? S_IDLE : S_DOT;
        end
        S_DOT: if (!out_v || m_ready) begin
          out_v <= 1'b1;
          out_c <= 8'h2E;
          out_l <= 1'b0;
          out_o <= ovf;
          fc <= prec;
          state <= S_FRAC;
        end
        S_FRAC: if (!out_v || m_ready) begin
          out_v <= 1'b1;
          out_c <= 8'h30 + {4'd0, lo10[67:64]};
          out_l <= (fc == 4'd1);
          out_o <= ovf;
          lo <= lo10[63:0];
          fc <= fc - 4'd1;
          if (fc == 4'd1) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/double_to_decimal_text.sv =====
// The front end classifies and rounds; the back end then divides out each
// integer digit (a digit of zero for value zero) and sends one character
// per cycle unless m_tready stalls. One number at a time in the back end;
// the front end queues up to three numbers ahead.
// Reset: rst synchronous, active high; clears all control and empties queue.
module double_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // value_bits[63:0], precision[68:64], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_char[7:0]
  output logic        m_tlast,
  output logic        m_tuser   // overflow
);
  import dtdt_pkg::*;

  logic      f_valid;
  logic      f_ready;
  dtdt_job_t f_job;
  logic      q_valid;
  logic      q_ready;
  dtdt_job_t q_job;

  dtdt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .value_bits(s_tdata[63:0]), .precision(s_tdata[68:64]),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  dtdt_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
  );

  dtdt_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .m_valid(m_tvalid), .m_ready(m_tready),
    .m_char(m_tdata), .m_last(m_tlast), .m_ovf(m_tuser)
  );

endmodule
